// ===== rtl/core/hhmc_pkg.sv =====
// Shared types, constants and helpers for the hit histogram to miss curve block
`default_nettype none

package hhmc_pkg;

	localparam int DEPTH  = 1024;
	localparam int AW     = $clog2(DEPTH);
	localparam int POS_W  = 10;
	localparam int CNT_W  = 32;
	localparam int SUM_W  = 48;
	localparam int QDEPTH = 2;
	localparam int QAW    = $clog2(QDEPTH);
	localparam int QCW    = $clog2(QDEPTH + 1);

	typedef enum logic {
		OP_RECORD = 1'b0,
		OP_DRAIN  = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		S_CLEAR,
		S_IDLE,
		S_EXEC
	} bk_state_t;

	typedef struct packed {
		logic              kind;
		logic [CNT_W-1:0]  position;
		logic [CNT_W-1:0]  hit_count;
	} in_t;

	typedef struct packed {
		logic [POS_W-1:0]  point_position;
		logic [SUM_W-1:0]  miss_count;
		logic              last;
	} out_t;

	typedef struct packed {
		op_t               op;
		logic [AW-1:0]     addr;
		logic [CNT_W-1:0]  cnt;
	} cmd_t;

	function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] a,
		input logic [SUM_W-1:0] b);
		logic [SUM_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[SUM_W] ? {SUM_W{1'b1}} : s[SUM_W-1:0];
	endfunction

endpackage

`default_nettype wire

// ===== rtl/core/hit_histogram_to_miss_curve.sv =====
// Top level: LRU stack distance histogram and miss curve generator
// Usage:
//   item channel (item_valid/item_ready/item) takes one word per command.
//   kind 0 records hit_count hits at an LRU stack position (clamped to
//   DEPTH-2); kind 1 drains the next miss curve point, positions 0 up to
//   highest recorded position plus one, each bin cleared as it is read.
//   point channel (point_valid/point_ready/point) returns one word per drain
//   with the position, miss count and a last flag that closes the batch.
// Timing:
//   a word sits in a two-entry command queue, then the back end issues the
//   bin memory read as it pops the word in the idle state and writes the
//   update in the exec state. It takes no new word until that read-modify-write
//   of the bin memory is done, with no forwarding between words. A drain's point
//   is loaded into the output register in the exec state. Records produce no output word.
// Reset:
//   after arst_n is released the bin memory is zeroed one entry a cycle,
//   all DEPTH (1024) entries, with item_ready low throughout.
// Stalls:
//   the result sits in an output register; while it is held with point_ready low,
//   the queue keeps filling and records execute, but a drain at the head waits.
`default_nettype none

module hit_histogram_to_miss_curve import hhmc_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic item_valid,
	output logic      item_ready,
	input  wire in_t  item,
	output logic      point_valid,
	input  wire logic point_ready,
	output out_t      point
);

	logic q_valid;
	logic q_ready;
	cmd_t q_cmd;
	logic clearing;

	hhmc_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.item       (item),
		.clearing   (clearing),
		.q_valid    (q_valid),
		.q_ready    (q_ready),
		.q_cmd      (q_cmd)
	);

	hhmc_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_valid     (q_valid),
		.q_ready     (q_ready),
		.q_cmd       (q_cmd),
		.clearing    (clearing),
		.point_valid (point_valid),
		.point_ready (point_ready),
		.point       (point)
	);

endmodule

`default_nettype wire

// ===== rtl/core/hhmc_ram.sv =====
// Generic simple dual-port RAM with registered read
`default_nettype none

module hhmc_ram #(
	parameter int W = 8,
	parameter int D = 16
) (
	input  wire logic                 clk,
	input  wire logic                 we,
	input  wire logic [$clog2(D)-1:0] waddr,
	input  wire logic [W-1:0]         wdata,
	input  wire logic [$clog2(D)-1:0] raddr,
	output logic      [W-1:0]         rdata
);

	logic [W-1:0] mem_q [D];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

// ===== rtl/core/hhmc_front.sv =====
// Front end: accepts words, clamps positions and queues commands
`default_nettype none

module hhmc_front import hhmc_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic item_valid,
	output logic      item_ready,
	input  wire in_t  item,
	input  wire logic clearing,
	output logic      q_valid,
	input  wire logic q_ready,
	output cmd_t      q_cmd
);

	cmd_t           fifo_q [QDEPTH];
	logic [QAW-1:0] wp_q;
	logic [QAW-1:0] rp_q;
	logic [QCW-1:0] cnt_q;
	logic           push;
	logic           pop;
	cmd_t           cmd_in;

	always_comb begin
		cmd_in.op  = op_t'(item.kind);
		cmd_in.cnt = item.hit_count;
		if (item.position > CNT_W'(DEPTH - 2)) begin
			cmd_in.addr = AW'(DEPTH - 2);
		end else begin
			cmd_in.addr = item.position[AW-1:0];
		end
	end

	assign item_ready = (cnt_q != QCW'(QDEPTH)) && !clearing;
	assign push       = item_valid && item_ready;
	assign q_valid    = (cnt_q != '0);
	assign pop        = q_valid && q_ready;
	assign q_cmd      = fifo_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wp_q] <= cmd_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= wp_q + 1'b1;
			end
			if (pop) begin
				rp_q <= rp_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/hhmc_back.sv =====
// Back end: bin read-modify-write, batch state and the result register
`default_nettype none

module hhmc_back import hhmc_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic q_valid,
	output logic      q_ready,
	input  wire cmd_t q_cmd,
	output logic      clearing,
	output logic      point_valid,
	input  wire logic point_ready,
	output out_t      point
);

	bk_state_t       state_q, state_d;
	logic [AW-1:0]   clr_idx_q;
	cmd_t            cmd_q;
	logic [AW-1:0]   highest_q;
	logic [SUM_W-1:0] total_q;
	logic [AW-1:0]   cursor_q;
	logic [SUM_W-1:0] prefix_q;
	logic            out_valid_q;
	out_t            out_q;

	logic            ram_we;
	logic [AW-1:0]   ram_waddr;
	logic [SUM_W-1:0] ram_wdata;
	logic [AW-1:0]   ram_raddr;
	logic [SUM_W-1:0] ram_rdata;

	logic            pop;
	logic            exec;
	logic            is_drain;
	logic            is_last;
	logic            out_load;
	logic [SUM_W-1:0] prefix_new;
	logic [SUM_W-1:0] cnt_ext;
	logic [SUM_W-1:0] miss;

	hhmc_ram #(
		.W (SUM_W),
		.D (DEPTH)
	) u_bins (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign cnt_ext    = SUM_W'(cmd_q.cnt);
	assign is_drain   = (cmd_q.op == OP_DRAIN);
	assign prefix_new = sat_add(prefix_q, ram_rdata);
	assign is_last    = ({1'b0, cmd_q.addr} >= ({1'b0, highest_q} + 1'b1));
	assign miss       = (total_q >= prefix_new) ? (total_q - prefix_new) : '0;

	always_comb begin
		state_d   = state_q;
		clearing  = 1'b0;
		q_ready   = 1'b0;
		exec      = 1'b0;
		ram_we    = 1'b0;
		ram_waddr = cmd_q.addr;
		ram_wdata = '0;
		ram_raddr = (q_cmd.op == OP_DRAIN) ? cursor_q : q_cmd.addr;
		unique case (state_q)
			S_CLEAR: begin
				clearing  = 1'b1;
				ram_we    = 1'b1;
				ram_waddr = clr_idx_q;
				if (clr_idx_q == AW'(DEPTH - 1)) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				q_ready = (q_cmd.op == OP_RECORD) || !out_valid_q || point_ready;
				if (q_valid && q_ready) begin
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				exec      = 1'b1;
				ram_we    = 1'b1;
				ram_wdata = is_drain ? '0 : sat_add(ram_rdata, cnt_ext);
				state_d   = S_IDLE;
			end
			default: begin
				state_d = S_CLEAR;
			end
		endcase
	end

	assign pop         = q_valid && q_ready;
	assign out_load    = exec && is_drain;
	assign point_valid = out_valid_q;
	assign point       = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cmd_q.op   <= q_cmd.op;
			cmd_q.cnt  <= q_cmd.cnt;
			cmd_q.addr <= ram_raddr;
		end
		if (out_load) begin
			out_q.point_position <= POS_W'(cmd_q.addr);
			out_q.miss_count     <= miss;
			out_q.last           <= is_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_idx_q   <= '0;
			highest_q   <= '0;
			total_q     <= '0;
			cursor_q    <= '0;
			prefix_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == S_CLEAR) begin
				clr_idx_q <= clr_idx_q + 1'b1;
			end
			if (exec && !is_drain) begin
				total_q <= sat_add(total_q, cnt_ext);
				if (cmd_q.addr > highest_q) begin
					highest_q <= cmd_q.addr;
				end
			end
			if (out_load) begin
				if (is_last) begin
					highest_q <= '0;
					total_q   <= '0;
					cursor_q  <= '0;
					prefix_q  <= '0;
				end else begin
					cursor_q <= cmd_q.addr + 1'b1;
					prefix_q <= prefix_new;
				end
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (point_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_load && out_valid_q) |-> point_ready)
		else $error("result register overwritten before it was taken");

	a_no_pop_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CLEAR) |-> !q_ready)
		else $error("command taken during bin clearing");

	a_cursor_bound: assert property (@(posedge clk) disable iff (!arst_n)
		({1'b0, cursor_q} <= ({1'b0, highest_q} + 1'b1)))
		else $error("drain cursor beyond highest position plus one");

	a_batch_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(out_load && is_last) |=> (cursor_q == '0 && total_q == '0 && prefix_q == '0))
		else $error("batch state not cleared after last point");

endmodule

`default_nettype wire

// ===== tb/sv/hhmc_curve_checker.sv =====
// Checker for the hit histogram to miss curve block: predicts each miss curve point and compares
`default_nettype none

module hhmc_curve_checker import hhmc_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic item_valid,
	input  wire logic item_ready,
	input  wire in_t  item,
	input  wire logic point_valid,
	input  wire logic point_ready,
	input  wire out_t point,
	output int        mismatches,
	output int        outstanding
);

	localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

	logic [SUM_W-1:0] bin_sum [DEPTH];
	logic [POS_W-1:0] top_pos;
	logic [SUM_W-1:0] total_hits;
	logic [SUM_W-1:0] walked_hits;
	logic [POS_W-1:0] cursor;
	out_t             pending_points [$];

	out_t             want;
	logic [POS_W-1:0] slot;

	function automatic logic [SUM_W-1:0] add_clip(input logic [SUM_W-1:0] a,
		input logic [SUM_W-1:0] b);
		return (a > SUM_MAX - b) ? SUM_MAX : a + b;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DEPTH; i++)
				bin_sum[i] = '0;
			top_pos = '0;
			total_hits = '0;
			walked_hits = '0;
			cursor = '0;
			pending_points.delete();
			mismatches = 0;
			outstanding = 0;
		end else begin
			if (point_valid && point_ready) begin
				if (pending_points.size() == 0) begin
					$display("%0t: unexpected point: expected none, got pos %0d miss %0d last %0b",
						$time, point.point_position, point.miss_count, point.last);
					mismatches++;
				end else begin
					want = pending_points.pop_front();
					if (point.point_position !== want.point_position) begin
						$display("%0t: point_position: expected %0d, got %0d",
							$time, want.point_position, point.point_position);
						mismatches++;
					end
					if (point.miss_count !== want.miss_count) begin
						$display("%0t: miss_count at pos %0d: expected %0d, got %0d",
							$time, want.point_position, want.miss_count, point.miss_count);
						mismatches++;
					end
					if (point.last !== want.last) begin
						$display("%0t: last at pos %0d: expected %0b, got %0b",
							$time, want.point_position, want.last, point.last);
						mismatches++;
					end
				end
			end
			if (item_valid && item_ready) begin
				if (item.kind == OP_RECORD) begin
					if (item.position > CNT_W'(DEPTH - 2))
						slot = POS_W'(DEPTH - 2);
					else
						slot = item.position[POS_W-1:0];
					bin_sum[slot] = add_clip(bin_sum[slot], SUM_W'(item.hit_count));
					total_hits = add_clip(total_hits, SUM_W'(item.hit_count));
					if (slot > top_pos)
						top_pos = slot;
				end else begin
					slot = cursor;
					walked_hits = add_clip(walked_hits, bin_sum[slot]);
					bin_sum[slot] = '0;
					want.point_position = slot;
					want.miss_count = (total_hits >= walked_hits) ? total_hits - walked_hits : '0;
					want.last = ({1'b0, slot} >= {1'b0, top_pos} + 11'd1);
					pending_points.push_back(want);
					if (want.last) begin
						top_pos = '0;
						total_hits = '0;
						walked_hits = '0;
						cursor = '0;
					end else begin
						cursor = slot + 1'b1;
					end
				end
			end
			outstanding = pending_points.size();
		end
	end

endmodule

`default_nettype wire

// ===== tb/sv/tb_top.sv =====
// Testbench top for the hit histogram to miss curve block: stimulus, handshakes and verdict
`default_nettype none

module tb_top;
	import hhmc_pkg::*;

	localparam int LIMIT = 1000000;
	localparam int RANDOM_WORDS = 700;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic item_valid = 1'b0;
	in_t  item = '0;
	logic point_ready = 1'b0;
	logic item_ready;
	logic point_valid;
	out_t point;

	int mismatches;
	int outstanding;
	int cycle_count = 0;
	int send_idle_pct = 31;
	int recv_idle_pct = 51;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	hit_histogram_to_miss_curve DUT (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.item(item),
		.point_valid(point_valid),
		.point_ready(point_ready),
		.point(point)
	);

	hhmc_curve_checker u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.item(item),
		.point_valid(point_valid),
		.point_ready(point_ready),
		.point(point),
		.mismatches(mismatches),
		.outstanding(outstanding)
	);

	always @(negedge clk) begin
		point_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= LIMIT) begin
			$display("hit_histogram_to_miss_curve: mismatch");
			$finish;
		end
	end

	task automatic send_word(input in_t w);
		@(negedge clk);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			item_valid <= 1'b0;
			@(negedge clk);
		end
		item_valid <= 1'b1;
		item <= w;
		do @(posedge clk); while (!item_ready);
	endtask

	task automatic put_record(input logic [CNT_W-1:0] pos, input logic [CNT_W-1:0] hits);
		in_t w;
		w.kind = OP_RECORD;
		w.position = pos;
		w.hit_count = hits;
		send_word(w);
	endtask

	task automatic put_drain();
		in_t w;
		w.kind = OP_DRAIN;
		w.position = $urandom;
		w.hit_count = $urandom;
		send_word(w);
	endtask

	function automatic logic [CNT_W-1:0] pick_position();
		int r;
		r = $urandom_range(0, 299);
		if (r < 260)
			return $urandom_range(0, 31);
		else if (r < 299)
			return $urandom_range(0, 127);
		return $urandom;
	endfunction

	function automatic logic [CNT_W-1:0] pick_hits();
		int r;
		r = $urandom_range(0, 99);
		if (r < 10)
			return '1;
		else if (r < 30)
			return $urandom_range(0, 15);
		return $urandom;
	endfunction

	initial begin
		int sent;
		int nrec;
		int ndrain;
		int hi;
		logic [CNT_W-1:0] p;
		in_t w;

		repeat (11) @(negedge clk);
		arst_n <= 1'b1;

		// empty batch
		put_drain();
		put_drain();
		// small batch, late record lands below the cursor and carries over
		put_record(32'd0, 32'd0);
		put_record(32'd2, 32'hFFFF_FFFF);
		put_record(32'd1, 32'd1);
		put_drain();
		put_drain();
		put_record(32'd0, 32'hFFFF_FFFF);
		put_drain();
		put_drain();
		// clamped positions, full sweep
		put_record(32'h8000_0000, 32'd5);
		put_record(32'd1022, 32'd9);
		put_record(32'd1023, 32'd3);
		put_record(32'hFFFF_FFFF, 32'd2);
		repeat (DEPTH) put_drain();

		sent = 0;
		while (sent < RANDOM_WORDS) begin
			case (sent * 3 / RANDOM_WORDS)
				0: begin
					send_idle_pct = 31;
					recv_idle_pct = 51;
				end
				1: begin
					send_idle_pct = 51;
					recv_idle_pct = 31;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			if ($urandom_range(0, 99) < 8) begin
				w.kind = op_t'($urandom_range(0, 1));
				w.position = $urandom;
				w.hit_count = $urandom;
				send_word(w);
				sent++;
			end else begin
				nrec = $urandom_range(1, 12);
				hi = 0;
				repeat (nrec) begin
					p = pick_position();
					if (p > CNT_W'(DEPTH - 2))
						p = CNT_W'(DEPTH - 2);
					if (int'(p) > hi)
						hi = p;
					put_record(p, pick_hits());
					sent++;
				end
				ndrain = hi + 2;
				if (ndrain > 130)
					ndrain = 130;
				if ($urandom_range(0, 99) < 10)
					ndrain = $urandom_range(1, ndrain);
				repeat (ndrain) begin
					if ($urandom_range(0, 99) < 5) begin
						put_record(pick_position(), pick_hits());
						sent++;
					end
					put_drain();
					sent++;
				end
			end
		end
		@(negedge clk);
		item_valid <= 1'b0;

		while (outstanding != 0) @(posedge clk);
		repeat (16) @(posedge clk);
		if (mismatches == 0)
			$display("hit_histogram_to_miss_curve: match");
		else
			$display("hit_histogram_to_miss_curve: mismatch");
		$finish;
	end

endmodule

`default_nettype wire

// ===== sim.f =====
rtl/core/hhmc_pkg.sv
rtl/core/hhmc_ram.sv
rtl/core/hhmc_front.sv
rtl/core/hhmc_back.sv
rtl/core/hit_histogram_to_miss_curve.sv
tb/sv/hhmc_curve_checker.sv
tb/sv/tb_top.sv
